// ----- design/mbps_pkg.sv -----
`default_nettype none

package mbps_pkg;

  // Pattern register geometry
  localparam int PAT_BYTES  = 16;
  localparam int IDX_W      = 4;
  localparam int LEN_W      = 5;
  localparam int CARE_W     = 16;
  localparam int OFS_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LO = 2'd0,
    REG_PAT_HI = 2'd1,
    REG_CARE   = 2'd2,
    REG_LEN    = 2'd3
  } cfg_reg_t;

  // Per-cycle control shared by every window cell
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  // Pattern byte a cell compares against
  typedef struct packed {
    logic       active;
    logic [7:0] value;
  } cell_pat_t;

  // One search result
  typedef struct packed {
    logic             found;
    logic [OFS_W-1:0] offset;
  } result_t;

endpackage

`default_nettype wire

// ----- design/mbps_cell.sv -----
`default_nettype none

// One window position: holds a haystack byte, passes it on each shift and
// checks the byte moving in against the pattern byte aimed at this position.
module mbps_cell (
  input  wire                 clk,
  input  wire                 rst_n,
  input  mbps_pkg::cell_ctrl_t ctrl,
  input  wire  [7:0]          byte_in,
  input  mbps_pkg::cell_pat_t pat,
  output logic [7:0]          byte_out,
  output logic                hit
);
  import mbps_pkg::*;

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;

  // Clear at end of haystack wins over shift
  always_comb begin
    byte_nxt = byte_r;
    if (ctrl.clear) begin
      byte_nxt = 8'h00;
    end else if (ctrl.shift) begin
      byte_nxt = byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= 8'h00;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  // Wildcards and positions outside the pattern always pass
  assign hit      = !pat.active || (byte_in == pat.value);
  assign byte_out = byte_r;

endmodule

`default_nettype wire

// ----- design/mbps_out_buf.sv -----
`default_nettype none

// Two-entry result queue: output register plus skid entry, so the input side
// keeps flowing while one result waits downstream.
module mbps_out_buf (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               push,
  input  mbps_pkg::result_t push_data,
  output logic              full,
  output logic              out_valid,
  input  wire               out_stall,
  output mbps_pkg::result_t out_data
);
  import mbps_pkg::*;

  logic    head_vld_r, head_vld_nxt;
  logic    skid_vld_r, skid_vld_nxt;
  result_t head_r, head_nxt;
  result_t skid_r, skid_nxt;
  logic    pop;

  assign pop = head_vld_r && !out_stall;

  always_comb begin
    head_vld_nxt = head_vld_r;
    skid_vld_nxt = skid_vld_r;
    head_nxt     = head_r;
    skid_nxt     = skid_r;
    // Drain: skid moves up into the output register
    if (pop) begin
      head_vld_nxt = skid_vld_r;
      head_nxt     = skid_r;
      skid_vld_nxt = 1'b0;
    end
    // Fill the first free slot
    if (push) begin
      if (!head_vld_nxt) begin
        head_vld_nxt = 1'b1;
        head_nxt     = push_data;
      end else begin
        skid_vld_nxt = 1'b1;
        skid_nxt     = push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      head_vld_r <= head_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_vld_r;
  assign out_valid = head_vld_r;
  assign out_data  = head_r;

endmodule

`default_nettype wire

// ----- design/masked_byte_pattern_search.sv -----
`default_nettype none

// Masked byte pattern search. Takes one haystack byte per cycle, back to back,
// when in_stall is low, and reports the first offset at which the newest
// pattern_length bytes match the pattern on every byte whose care bit is set;
// a haystack that ends with no match gives found=0 at its last byte. A row of
// MAX_PATTERN_BYTES cells holds the sliding window; each cell compares the
// byte entering it against its pattern byte in the same cycle, so a byte's
// result is queued as the byte is taken. The cycle is set by the cell compares
// plus the AND across the row and the offset subtract. A two-entry output
// queue lets the input run while one result waits; in_stall rises only when
// both entries hold results. Register writes apply from the next byte.
module masked_byte_pattern_search #(
  parameter int MAX_PATTERN_BYTES = 16,
  parameter int OFFSET_BITS       = 32
) (
  input  wire                                clk,
  input  wire                                rst_n,
  // configuration
  input  wire                                cfg_wr_en,
  input  wire  [mbps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [mbps_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // haystack bytes
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire  [7:0]                         in_data_byte,
  input  wire                                in_last_byte,
  // results
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic                               out_found,
  output logic [mbps_pkg::OFS_W-1:0]         out_match_offset
);
  import mbps_pkg::*;

  localparam int LEN_CAP = (MAX_PATTERN_BYTES < PAT_BYTES) ? MAX_PATTERN_BYTES : PAT_BYTES;
  localparam int WIDE    = (OFFSET_BITS > OFS_W) ? OFFSET_BITS : OFS_W;
  localparam logic [OFFSET_BITS-1:0] CNT_MAX = {OFFSET_BITS{1'b1}};

  // Configuration registers
  logic [CFG_DATA_W-1:0] pat_lo_r;
  logic [CFG_DATA_W-1:0] pat_hi_r;
  logic [CARE_W-1:0]     care_r;
  logic [LEN_W-1:0]      len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r <= '0;
      pat_hi_r <= '0;
      care_r   <= '0;
      len_r    <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PAT_LO: pat_lo_r <= cfg_wdata;
        REG_PAT_HI: pat_hi_r <= cfg_wdata;
        REG_CARE:   care_r   <= cfg_wdata[CARE_W-1:0];
        REG_LEN:    len_r    <= cfg_wdata[LEN_W-1:0];
      endcase
    end
  end

  logic [8*PAT_BYTES-1:0] pat_all;
  assign pat_all = {pat_hi_r, pat_lo_r};

  // Input transaction and stream control
  logic       in_acc;
  logic       reported_r, reported_nxt;
  cell_ctrl_t cell_ctrl;
  logic       out_full;

  assign in_stall       = out_full;
  assign in_acc         = in_valid && !in_stall;
  assign cell_ctrl.shift = in_acc && !reported_r;
  assign cell_ctrl.clear = in_acc && in_last_byte;

  // Window cell row
  logic [7:0]                   win [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0] hits;

  genvar k;
  generate
    for (k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
      logic [7:0] byte_in;
      cell_pat_t  pat;

      if (k == 0) begin : g_head
        assign byte_in = in_data_byte;
      end else begin : g_link
        assign byte_in = win[k-1];
      end

      // Cell k sees pattern byte len-1-k when k is inside the pattern
      if (k < PAT_BYTES) begin : g_sel
        logic [LEN_W-1:0] idx_full;
        logic [IDX_W-1:0] idx;
        assign idx_full   = len_r - LEN_W'(k + 1);
        assign idx        = idx_full[IDX_W-1:0];
        assign pat.active = (len_r > LEN_W'(k)) && care_r[idx];
        assign pat.value  = pat_all[8*idx +: 8];
      end else begin : g_idle
        assign pat.active = 1'b0;
        assign pat.value  = 8'h00;
      end

      mbps_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (cell_ctrl),
        .byte_in  (byte_in),
        .pat      (pat),
        .byte_out (win[k]),
        .hit      (hits[k])
      );
    end
  endgenerate

  // Saturating byte counter
  logic [OFFSET_BITS-1:0] cnt_r, cnt_nxt, cnt_inc;

  assign cnt_inc = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;

  always_comb begin
    cnt_nxt = cnt_r;
    if (cell_ctrl.clear) begin
      cnt_nxt = '0;
    end else if (cell_ctrl.shift) begin
      cnt_nxt = cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Match decision and start offset
  logic            len_ok;
  logic            cnt_ok;
  logic            match;
  logic [WIDE-1:0] cnt_w, len_w, diff_w;
  result_t         res;
  logic            res_push;

  assign len_ok = (len_r != '0) && (len_r <= LEN_W'(LEN_CAP));
  assign cnt_w  = WIDE'(cnt_inc);
  assign len_w  = WIDE'(len_r);
  assign cnt_ok = cnt_w >= len_w;
  assign diff_w = cnt_w - len_w;
  assign match  = len_ok && cnt_ok && (&hits);

  assign res_push   = cell_ctrl.shift && (match || in_last_byte);
  assign res.found  = match;
  assign res.offset = match ? diff_w[OFS_W-1:0] : '0;

  // Reported flag: quiet until end of haystack
  always_comb begin
    reported_nxt = reported_r;
    if (cell_ctrl.clear) begin
      reported_nxt = 1'b0;
    end else if (cell_ctrl.shift && match) begin
      reported_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reported_r <= 1'b0;
    end else begin
      reported_r <= reported_nxt;
    end
  end

  // Result queue
  result_t out_data;

  mbps_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res),
    .full      (out_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_found        = out_data.found;
  assign out_match_offset = out_data.offset;

endmodule

`default_nettype wire

// ----- design/mbps_checker.sv -----
`default_nettype none

// Port-level checks for the pattern search block
module mbps_checker (
  input wire                        clk,
  input wire                        rst_n,
  input wire                        in_stall,
  input wire                        out_valid,
  input wire                        out_stall,
  input wire                        out_found,
  input wire [mbps_pkg::OFS_W-1:0]  out_match_offset
);
  import mbps_pkg::*;

  // No result leaves right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_found)
      && $stable(out_match_offset))
    else $error("stalled result changed");

  // A miss carries a zero offset
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_match_offset == '0)
    else $error("miss with nonzero offset");

  // Input backpressure only when results are queued behind a stall
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  a_stall_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_stall))
    else $error("input stall rose without output stall");

endmodule

bind masked_byte_pattern_search mbps_checker u_mbps_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_found        (out_found),
  .out_match_offset (out_match_offset)
);

`default_nettype wire

// ----- tb/masked_byte_pattern_search_test.sv -----
`default_nettype none

module masked_byte_pattern_search_test;
  import mbps_pkg::*;

  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 4;
  localparam int RUN_LIMIT     = 1000000;
  localparam int NUM_PROBES    = 19;
  localparam int PHASE_ITEMS   = 120;
  localparam int NUM_PHASES    = 12;

  // Directed setups, loaded ahead of a probe row
  localparam logic [2:0] KEEP         = 3'd0;
  localparam logic [2:0] SET_DEADBEEF = 3'd1;
  localparam logic [2:0] SET_TOO_LONG = 3'd2;
  localparam logic [2:0] SET_ANY_BYTE = 3'd3;

  localparam logic [127:0] DEADBEEF_PAT = 128'h0000_0000_0000_0000_0000_0000_EFBE_ADDE;

  typedef struct packed {
    logic [2:0]  setup;
    logic [7:0]  data;
    logic        last;
    logic        typed;   // expected result given in the row
    logic        has;
    logic        found;
    logic [31:0] offset;
  } probe_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_PAT_LO;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_data_byte = '0;
  logic                  in_last_byte = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_found;
  logic [OFS_W-1:0]      out_match_offset;

  // Row info that travels with the byte payload
  logic    row_typed = 1'b0;
  logic    row_has_result = 1'b0;
  result_t row_result = '0;

  // Search state mirror
  logic [8*PAT_BYTES-1:0] pat_bits = '0;
  logic [CARE_W-1:0]      care_mask = '0;
  logic [LEN_W-1:0]       pat_len = '0;
  logic [7:0]             window [PAT_BYTES] = '{default: 8'h00};
  logic [OFS_W-1:0]       seen = '0;
  bit                     reported = 1'b0;

  result_t pending_results[$];
  result_t predicted;
  result_t oldest;
  bit      predicted_valid;
  int      mismatches = 0;

  // Stimulus control shared by the sender and the receiver
  logic [127:0] cur_pat = '0;
  logic [15:0]  cur_care = '0;
  logic [4:0]   cur_len = '0;
  int           idle_rate = 0;
  bit           calm = 1'b0;
  int           hold_asks = 0;
  int           hold_served = 0;
  int           items_sent = 0;
  probe_t       probes [NUM_PROBES];

  masked_byte_pattern_search dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_found       (out_found),
    .out_match_offset(out_match_offset)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #(RUN_LIMIT);
    $display("FAIL");
    $finish;
  end

  // Newest pat_len bytes against the pattern, wildcards skipped
  function automatic bit window_hit();
    int j;
    if (pat_len == 0 || pat_len > PAT_BYTES) return 1'b0;
    if (seen < pat_len) return 1'b0;
    for (j = 0; j < pat_len; j++)
      if (care_mask[j] && window[pat_len - 1 - j] != pat_bits[8*j +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  // Advance the mirror by one byte; returns 1 when a result is due
  function automatic bit predict_search(input logic [7:0] b, input logic last,
                                        output result_t res);
    int k;
    bit emits;
    emits = 1'b0;
    res = '0;
    if (!reported) begin
      for (k = PAT_BYTES - 1; k > 0; k--) window[k] = window[k - 1];
      window[0] = b;
      if (seen != '1) seen++;
      if (window_hit()) begin
        res.found = 1'b1;
        res.offset = seen - pat_len;
        reported = 1'b1;
        emits = 1'b1;
      end else if (last) begin
        emits = 1'b1;
      end
    end
    // end of haystack: back to a clean stream
    if (last) begin
      window = '{default: 8'h00};
      seen = '0;
      reported = 1'b0;
    end
    return emits;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatches++;
    $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
  endtask

  // Mirror register writes, predict on byte transactions, check result transactions
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_PAT_LO: pat_bits[63:0] = cfg_wdata;
          REG_PAT_HI: pat_bits[127:64] = cfg_wdata;
          REG_CARE:   care_mask = cfg_wdata[CARE_W-1:0];
          REG_LEN:    pat_len = cfg_wdata[LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predicted_valid = predict_search(in_data_byte, in_last_byte, predicted);
        if (row_typed) begin
          predicted_valid = row_has_result;
          predicted = row_result;
        end
        if (predicted_valid) pending_results.push_back(predicted);
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: expected none, got found=%0b offset=%0h",
                   $time, out_found, out_match_offset);
        end else begin
          oldest = pending_results.pop_front();
          if (out_found !== oldest.found)
            flag_mismatch("found", oldest.found, out_found);
          if (out_match_offset !== oldest.offset)
            flag_mismatch("match_offset", oldest.offset, out_match_offset);
        end
      end
    end
  end

  // Receiver: random stall bursts, plus a long hold when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_asks != hold_served) begin
        hold_served = hold_asks;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!calm && idle_rate != 0 && $urandom_range(idle_rate - 1, 0) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(10, 1)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [127:0] random_pattern();
    return {$urandom(), $urandom(), $urandom(), $urandom()};
  endfunction

  // Half plain random, half taken from the pattern to provoke partial matches
  function automatic logic [7:0] noise_byte();
    int j;
    j = $urandom_range(PAT_BYTES - 1, 0);
    if ($urandom_range(1, 0) == 0) return 8'($urandom());
    return cur_pat[8*j +: 8];
  endfunction

  // One byte transaction; called at a clock edge, ends at or after the accepting edge
  task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                           input logic has, input result_t res);
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    row_typed <= typed;
    row_has_result <= has;
    row_result <= res;
    do @(posedge clk); while (in_stall);
    if (!calm && idle_rate != 0 && $urandom_range(idle_rate - 1, 0) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(10, 1)) @(posedge clk);
    end
  endtask

  // Wait for every outstanding result, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // All four registers, upper data bits filled with junk where they are unused
  task automatic load_pattern(input logic [127:0] pat, input logic [15:0] care,
                              input logic [4:0] len);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_PAT_LO;
    cfg_wdata <= pat[63:0];
    @(posedge clk);
    cfg_index <= REG_PAT_HI;
    cfg_wdata <= pat[127:64];
    @(posedge clk);
    cfg_index <= REG_CARE;
    cfg_wdata <= {$urandom(), 16'($urandom()), care};
    @(posedge clk);
    cfg_index <= REG_LEN;
    cfg_wdata <= {$urandom(), 27'($urandom()), len};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_pat = pat;
    cur_care = care;
    cur_len = len;
  endtask

  // Noise, then often the pattern (sometimes with a bad byte or cut short), then noise
  task automatic send_haystack();
    logic [7:0] hay[$];
    int j, span, slip, stop, tail;
    span = (cur_len > PAT_BYTES) ? PAT_BYTES : cur_len;
    tail = $urandom_range(6, 0);
    repeat (($urandom_range(15, 0) == 0) ? $urandom_range(80, 30) : $urandom_range(12, 0))
      hay.push_back(noise_byte());
    if (span > 0 && $urandom_range(1, 0) == 1) begin
      slip = ($urandom_range(3, 0) == 0) ? $urandom_range(span - 1, 0) : -1;
      stop = ($urandom_range(5, 0) == 0) ? $urandom_range(span, 1) : span;
      for (j = 0; j < stop; j++)
        hay.push_back((cur_care[j] && j != slip) ? cur_pat[8*j +: 8] : 8'($urandom()));
      if (stop < span) tail = 0;
    end
    repeat (tail) hay.push_back(noise_byte());
    if (hay.size() == 0) hay.push_back(noise_byte());
    for (j = 0; j < hay.size(); j++)
      send_byte(hay[j], j == hay.size() - 1, 1'b0, 1'b0, '0);
    items_sent += hay.size();
  endtask

  // Stimulus: directed probes, a backpressure burst, then random phases
  initial begin
    int i, phase, goal;
    probe_t row;
    probes = '{
      '{KEEP,         8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 32'd0},
      '{KEEP,         8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, 32'd0},
      '{SET_DEADBEEF, 8'h11, 1'b0, 1'b1, 1'b0, 1'b0, 32'd0},
      '{KEEP,         8'hDE, 1'b0, 1'b1, 1'b0, 1'b0, 32'd0},
      '{KEEP,         8'hAD, 1'b0, 1'b1, 1'b0, 1'b0, 32'd0},
      '{KEEP,         8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 32'd0},
      '{KEEP,         8'hEF, 1'b1, 1'b1, 1'b1, 1'b1, 32'd1},
      '{KEEP,         8'hDE, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
      '{KEEP,         8'hAD, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
      '{KEEP,         8'hBE, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
      '{KEEP,         8'hEF, 1'b0, 1'b1, 1'b1, 1'b1, 32'd0},
      '{KEEP,         8'hDE, 1'b0, 1'b1, 1'b0, 1'b0, 32'd0},
      '{KEEP,         8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 32'd0},
      '{KEEP,         8'hDE, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
      '{KEEP,         8'hAD, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0},
      '{KEEP,         8'hBE, 1'b1, 1'b1, 1'b1, 1'b0, 32'd0},
      '{SET_TOO_LONG, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, 32'd0},
      '{SET_ANY_BYTE, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 32'd0},
      '{KEEP,         8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 32'd0}
    };
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed probes; the first two run on the reset registers
    idle_rate = 4;
    for (i = 0; i < NUM_PROBES; i++) begin
      row = probes[i];
      case (row.setup)
        SET_DEADBEEF: begin
          drain();
          load_pattern(DEADBEEF_PAT, 16'hFFFB, 5'd4);
        end
        SET_TOO_LONG: begin
          drain();
          load_pattern(DEADBEEF_PAT, 16'hFFFF, 5'd20);
        end
        SET_ANY_BYTE: begin
          drain();
          load_pattern(random_pattern(), 16'h0000, 5'd1);
        end
        default: ;
      endcase
      send_byte(row.data, row.last, row.typed, row.has, {row.found, row.offset});
    end

    // Every one-byte haystack matches; the receiver holds off so the block backs up
    drain();
    load_pattern(random_pattern(), 16'h0000, 5'd1);
    idle_rate = 0;
    hold_asks++;
    repeat (40) send_byte(8'($urandom()), 1'b1, 1'b0, 1'b0, '0);

    // Random phases, extreme settings first
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      drain();
      case (phase)
        0: load_pattern({16{8'hFF}}, 16'hFFFF, 5'd16);
        1: load_pattern('0, 16'hFFFF, 5'd16);
        2: load_pattern(random_pattern(), 16'($urandom()), 5'd31);
        3: load_pattern(random_pattern(), 16'($urandom()), 5'd0);
        4: load_pattern(random_pattern(), 16'h0000, 5'd16);
        5: load_pattern(random_pattern(), 16'hFFFF, 5'd1);
        6: load_pattern(random_pattern(), 16'($urandom()), 5'($urandom_range(30, 17)));
        default: load_pattern(random_pattern(), 16'($urandom()), 5'($urandom_range(16, 1)));
      endcase
      calm = (phase >= NUM_PHASES - 2);
      idle_rate = (phase % 3 == 0) ? 4 : ((phase % 3 == 1) ? 12 : 0);
      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal) send_haystack();
    end

    drain();
    if (mismatches == 0 && pending_results.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
design/mbps_pkg.sv
design/mbps_cell.sv
design/mbps_out_buf.sv
design/masked_byte_pattern_search.sv
design/mbps_checker.sv
tb/masked_byte_pattern_search_test.sv
